// ----- sv/ordered_list_deque_engine_unit_defines.svh -----
// Assertion macros for the checker of the ordered list deque engine.
`ifndef ORDERED_LIST_DEQUE_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_LIST_DEQUE_ENGINE_UNIT_DEFINES_SVH

// clocked property, masked during reset
`define OLDE_ASSERT_ON(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same, on the usual clock and reset names
`define OLDE_ASSERT(lbl, prop, msg) \
   `OLDE_ASSERT_ON(lbl, clock, reset, prop, msg)

`endif

// ----- sv/olde_pkg.sv -----
// Shared constants, operation and status codes, and control types of the deque engine.
`default_nettype none
package olde_pkg;

   localparam int OLDE_CAPACITY   = 16;
   localparam int OLDE_DATA_WIDTH = 32;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_INSERT_AT  = 3'd2;
   localparam logic [2:0] OP_POP_FRONT  = 3'd3;
   localparam logic [2:0] OP_POP_BACK   = 3'd4;
   localparam logic [2:0] OP_REMOVE_AT  = 3'd5;
   localparam logic [2:0] OP_READ_AT    = 3'd6;
   localparam logic [2:0] OP_FIND       = 3'd7;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_EMPTY     = 3'd1;
   localparam logic [2:0] STAT_FULL      = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [2:0] STAT_BAD_INDEX = 3'd4;

   typedef struct packed {
      logic take;
      logic exec;
      logic scan_init;
      logic scan_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
      logic find_go;
      logic scan_done;
   } sts_type;

endpackage
`default_nettype wire

// ----- sv/olde_req_if.sv -----
// Request channel interface: valid, ready and the request payload.
`default_nettype none
interface olde_req_if #(
   parameter int IDX_W      = 4,
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic [2:0]                   op;
   logic [IDX_W-1:0]             index;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, output op, output index, output value, input ready);
   modport sink   (input valid, input op, input index, input value, output ready);
endinterface
`default_nettype wire

// ----- sv/olde_rsp_if.sv -----
// Response channel interface: valid, ready and the result payload.
`default_nettype none
interface olde_rsp_if #(
   parameter int IDX_W      = 4,
   parameter int CNT_W      = 5,
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] data;
   logic [IDX_W-1:0]             position;
   logic [CNT_W-1:0]             occupancy;
   logic [2:0]                   status;

   modport source (output valid, output data, output position, output occupancy,
                   output status, input ready);
   modport sink   (input valid, input data, input position, input occupancy,
                   input status, output ready);
endinterface
`default_nettype wire

// ----- sv/olde_ctrl.sv -----
// Controller state machine: accept, execute, scan for find, wait on the result register.
`default_nettype none
module olde_ctrl
   import olde_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == S_IDLE) & ~reset;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.find_go) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else if (!sts.out_busy) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (!sts.scan_done) begin
               cmd.scan_step = 1'b1;
            end else if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/olde_datapath.sv -----
// Datapath: request latch, shifting slot row, fill count, find scanner and result register.
`default_nettype none
module olde_datapath
   import olde_pkg::*;
#(
   parameter int CAPACITY   = OLDE_CAPACITY,
   parameter int DATA_WIDTH = OLDE_DATA_WIDTH,
   parameter int IDX_W      = $clog2(CAPACITY),
   parameter int CNT_W      = $clog2(CAPACITY + 1)
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  cmd_type                      cmd,
   output sts_type                      sts,
   input  logic [2:0]                   req_op,
   input  logic [IDX_W-1:0]             req_index,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_data,
   output logic [IDX_W-1:0]             rsp_position,
   output logic [CNT_W-1:0]             rsp_occupancy,
   output logic [2:0]                   rsp_status
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [2:0]                   op_ff;
   logic [IDX_W-1:0]             idx_ff;
   logic [DATA_WIDTH-1:0]        val_ff;
   logic [DATA_WIDTH-1:0]        slots_ff [CAPACITY];
   logic [DATA_WIDTH-1:0]        slots_in [CAPACITY];
   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic [IDX_W-1:0]             scan_ff;
   logic                         out_valid_ff;
   logic [DATA_WIDTH-1:0]        out_data_ff;
   logic [IDX_W-1:0]             out_pos_ff;
   logic [CNT_W-1:0]             out_occ_ff;
   logic [2:0]                   out_stat_ff;

   logic                         full;
   logic                         empty;
   logic [CNT_W-1:0]             idx_ext;
   logic [CNT_W-1:0]             at_ins;
   logic [CNT_W-1:0]             at_rm;
   logic [IDX_W-1:0]             rd_addr;
   logic [DATA_WIDTH-1:0]        rd_data;
   logic                         ins_ok;
   logic                         rm_ok;
   logic                         rd_ok;
   logic [2:0]                   exec_stat;
   logic                         scan_hit;
   logic                         scan_last;
   logic                         out_load;

   assign full    = (count_ff == CAP_CNT);
   assign empty   = (count_ff == '0);
   assign idx_ext = CNT_W'(idx_ff);

   always_comb begin
      case (op_ff)
         OP_PUSH_FRONT: at_ins = '0;
         OP_PUSH_BACK:  at_ins = count_ff;
         default:       at_ins = idx_ext;
      endcase
      case (op_ff)
         OP_POP_FRONT: at_rm = '0;
         OP_POP_BACK:  at_rm = count_ff - 1'b1;
         default:      at_rm = idx_ext;
      endcase
   end

   assign rd_addr = (op_ff == OP_FIND) ? scan_ff : at_rm[IDX_W-1:0];
   assign rd_data = slots_ff[rd_addr];

   always_comb begin
      ins_ok    = 1'b0;
      rm_ok     = 1'b0;
      rd_ok     = 1'b0;
      exec_stat = STAT_OK;
      case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
            if (full) begin
               exec_stat = STAT_FULL;
            end else if (at_ins > count_ff) begin
               exec_stat = STAT_BAD_INDEX;
            end else begin
               ins_ok = 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT, OP_READ_AT: begin
            if (empty) begin
               exec_stat = STAT_EMPTY;
            end else if (at_rm >= count_ff) begin
               exec_stat = STAT_BAD_INDEX;
            end else if (op_ff == OP_READ_AT) begin
               rd_ok = 1'b1;
            end else begin
               rm_ok = 1'b1;
            end
         end
         default: begin
            exec_stat = STAT_EMPTY;
         end
      endcase
   end

   // open or close a gap: each slot takes its own value, a neighbor's, or the new value
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         slots_in[i] = slots_ff[i];
         if (cmd.exec && ins_ok) begin
            if (CNT_W'(i) == at_ins) begin
               slots_in[i] = val_ff;
            end else if (i > 0 && CNT_W'(i) > at_ins) begin
               slots_in[i] = slots_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.exec && rm_ok) begin
            if (i < CAPACITY - 1 && CNT_W'(i) >= at_rm) begin
               slots_in[i] = slots_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.exec && ins_ok) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.exec && rm_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign scan_hit  = (rd_data == val_ff);
   assign scan_last = (CNT_W'(scan_ff) == count_ff - 1'b1);
   assign out_load  = cmd.exec | cmd.finish;

   assign sts.out_busy  = out_valid_ff & ~rsp_ready;
   assign sts.find_go   = (op_ff == OP_FIND) & ~empty;
   assign sts.scan_done = scan_hit | scan_last;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= req_op;
         idx_ff <= req_index;
         val_ff <= req_value;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         slots_ff[i] <= slots_in[i];
      end
      if (cmd.exec) begin
         out_data_ff <= (rm_ok || rd_ok) ? rd_data : '0;
         out_pos_ff  <= '0;
         out_occ_ff  <= count_in;
         out_stat_ff <= exec_stat;
      end else if (cmd.finish) begin
         out_data_ff <= '0;
         out_pos_ff  <= scan_hit ? scan_ff : '0;
         out_occ_ff  <= count_ff;
         out_stat_ff <= scan_hit ? STAT_OK : STAT_NOT_FOUND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_load | (out_valid_ff & ~rsp_ready);
         if (cmd.scan_init) begin
            scan_ff <= '0;
         end else if (cmd.scan_step) begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_data      = out_data_ff;
   assign rsp_position  = out_pos_ff;
   assign rsp_occupancy = out_occ_ff;
   assign rsp_status    = out_stat_ff;

endmodule
`default_nettype wire

// ----- sv/ordered_list_deque_engine_unit.sv -----
// Top level of the ordered list deque engine: controller plus datapath.
//
//   channel  | dir | payload                                  | handshake
//   req_ch   | in  | op, index, value                         | valid/ready
//   rsp_ch   | out | data, position, occupancy, status        | valid/ready
//
// Non-find operations go through accept, then execute once the result register is free.
// Find goes through accept, execute and a scan of the slots from the front, using the
// single slot read port that the scanner walks one slot per cycle.
// Reset clears the fill count, so the list starts empty; slot contents are not reset.
// A stalled result holds in the result register; the next request is accepted
// meanwhile and executes once that register frees up.
`default_nettype none
module ordered_list_deque_engine_unit
   import olde_pkg::*;
#(
   parameter int CAPACITY   = OLDE_CAPACITY,
   parameter int DATA_WIDTH = OLDE_DATA_WIDTH
)
(
   input  logic       clock,
   input  logic       reset,
   olde_req_if.sink   req_ch,
   olde_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   cmd_type cmd;
   sts_type sts;

   olde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   olde_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_op        (req_ch.op),
      .req_index     (req_ch.index),
      .req_value     (req_ch.value),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_data      (rsp_ch.data),
      .rsp_position  (rsp_ch.position),
      .rsp_occupancy (rsp_ch.occupancy),
      .rsp_status    (rsp_ch.status)
   );

endmodule
`default_nettype wire

// ----- sv/olde_checker.sv -----
// Port-level checker for the deque engine result channel, bound to the top level.
`default_nettype none
`include "ordered_list_deque_engine_unit_defines.svh"
module olde_checker
   import olde_pkg::*;
#(
   parameter int CAPACITY   = OLDE_CAPACITY,
   parameter int DATA_WIDTH = OLDE_DATA_WIDTH,
   parameter int IDX_W      = $clog2(CAPACITY),
   parameter int CNT_W      = $clog2(CAPACITY + 1)
)
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_data,
   input logic [IDX_W-1:0]      rsp_position,
   input logic [CNT_W-1:0]      rsp_occupancy,
   input logic [2:0]            rsp_status
);

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   `OLDE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_position) && $stable(rsp_occupancy) && $stable(rsp_status), "result beat changed while stalled")
   `OLDE_ASSERT(a_occ_range, rsp_valid |-> rsp_occupancy <= CAP_CNT, "occupancy above capacity")
   `OLDE_ASSERT(a_full_occ, rsp_valid && rsp_status == STAT_FULL |-> rsp_occupancy == CAP_CNT, "full status with room left")
   `OLDE_ASSERT(a_empty_occ, rsp_valid && rsp_status == STAT_EMPTY |-> rsp_occupancy == '0, "empty status with entries held")
   `OLDE_ASSERT(a_err_zero, rsp_valid && rsp_status != STAT_OK |-> rsp_data == '0 && rsp_position == '0, "error beat carries data")

endmodule

bind ordered_list_deque_engine_unit olde_checker #(
   .CAPACITY   (CAPACITY),
   .DATA_WIDTH (DATA_WIDTH),
   .IDX_W      (IDX_W),
   .CNT_W      (CNT_W)
) u_olde_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_data      (rsp_ch.data),
   .rsp_position  (rsp_ch.position),
   .rsp_occupancy (rsp_ch.occupancy),
   .rsp_status    (rsp_ch.status)
);
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench of the ordered list deque engine: list predictor, directed and random driving, and checking.
`timescale 1ns / 1ps
module testbench;
   import olde_pkg::*;

   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_ITEMS  = 1660;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct packed {
      logic signed [OLDE_DATA_WIDTH-1:0] data;
      logic [3:0]                        position;
      logic [4:0]                        occupancy;
      logic [2:0]                        status;
   } list_result_type;

   class deque_ledger_type;
      logic signed [OLDE_DATA_WIDTH-1:0] slots [OLDE_CAPACITY];
      int              fill;
      list_result_type awaiting [$];
      int              failures;
      int              requests;
      int              op_seen [8];
      int              status_seen [8];

      function new();
         fill     = 0;
         failures = 0;
         requests = 0;
         foreach (op_seen[k]) op_seen[k] = 0;
         foreach (status_seen[k]) status_seen[k] = 0;
      endfunction

      function int pending();
         return awaiting.size();
      endfunction

      function void note_request(logic [2:0] op, logic [3:0] idx,
                                 logic signed [OLDE_DATA_WIDTH-1:0] val);
         list_result_type r;
         int              at;
         int              k;
         bit              found;
         r        = '0;
         r.status = STAT_OK;
         found    = 1'b0;
         case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
               at = (op == OP_PUSH_FRONT) ? 0 : (op == OP_PUSH_BACK) ? fill : int'(idx);
               if (fill >= OLDE_CAPACITY) r.status = STAT_FULL;
               else if (at > fill) r.status = STAT_BAD_INDEX;
               else begin
                  for (k = fill; k > at; k--) slots[k] = slots[k-1];
                  slots[at] = val;
                  fill++;
               end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT: begin
               if (fill == 0) r.status = STAT_EMPTY;
               else begin
                  at = (op == OP_POP_FRONT) ? 0 : (op == OP_POP_BACK) ? fill - 1 : int'(idx);
                  if (at >= fill) r.status = STAT_BAD_INDEX;
                  else begin
                     r.data = slots[at];
                     for (k = at; k + 1 < fill; k++) slots[k] = slots[k+1];
                     fill--;
                  end
               end
            end
            OP_READ_AT: begin
               if (fill == 0) r.status = STAT_EMPTY;
               else if (int'(idx) >= fill) r.status = STAT_BAD_INDEX;
               else r.data = slots[idx];
            end
            default: begin
               if (fill == 0) r.status = STAT_EMPTY;
               else begin
                  r.status = STAT_NOT_FOUND;
                  for (k = 0; k < fill && !found; k++) begin
                     if (slots[k] == val) begin
                        found      = 1'b1;
                        r.position = k[3:0];
                        r.status   = STAT_OK;
                     end
                  end
               end
            end
         endcase
         r.occupancy = fill[4:0];
         awaiting.push_back(r);
         requests++;
         op_seen[op]++;
         status_seen[r.status]++;
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_response(logic signed [OLDE_DATA_WIDTH-1:0] data,
                                   logic [3:0] position, logic [4:0] occupancy,
                                   logic [2:0] status);
         list_result_type want;
         if (awaiting.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, got data %0d status %0d",
                     $time, data, status);
            failures++;
         end else begin
            want = awaiting.pop_front();
            compare_field("data", want.data, data);
            compare_field("position", want.position, position);
            compare_field("occupancy", want.occupancy, occupancy);
            compare_field("status", want.status, status);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   olde_req_if #(.IDX_W(4), .DATA_WIDTH(OLDE_DATA_WIDTH)) req_ch ();
   olde_rsp_if #(.IDX_W(4), .CNT_W(5), .DATA_WIDTH(OLDE_DATA_WIDTH)) rsp_ch ();

   ordered_list_deque_engine_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   deque_ledger_type ledger;
   int               gap_pct;
   int               stall_pct;
   int               stall_left;
   bit               hold_off_request;
   int               cycle_count;

   logic [2:0] grow_ops [3]  = '{OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT};
   logic [2:0] shrink_ops [3] = '{OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT};
   logic [2:0] look_ops [2]  = '{OP_READ_AT, OP_FIND};
   logic [2:0] every_op [8]  = '{OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT, OP_POP_FRONT,
                                 OP_POP_BACK, OP_REMOVE_AT, OP_READ_AT, OP_FIND};
   logic signed [31:0] value_pool [8] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000,
                                          -32'sd1, 32'sd1, 32'sh5A5A_5A5A,
                                          -32'sh0000_1234, 32'sh00C0_FFEE};

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, ledger.pending());
         $display("** ordered_list_deque_engine_unit: FAILED **");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold on request
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         stall_left       = LONG_HOLD;
      end else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         ledger.check_response(rsp_ch.data, rsp_ch.position, rsp_ch.occupancy, rsp_ch.status);
   end

   task automatic send_request(input logic [2:0] op, input logic [3:0] idx,
                               input logic signed [31:0] val);
      int gap;
      gap = 0;
      if ($urandom_range(0, 99) < gap_pct)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.index <= idx;
      req_ch.value <= val;
      do @(posedge clock); while (!req_ch.ready);
      ledger.note_request(op, idx, val);
   endtask

   function automatic logic signed [31:0] pick_value(logic [2:0] op);
      int roll;
      roll = $urandom_range(0, 99);
      if (op == OP_FIND && ledger.fill > 0 && roll < 60)
         return ledger.slots[$urandom_range(0, ledger.fill - 1)];
      if (roll < 35)
         return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic logic [3:0] pick_index(logic [2:0] op);
      bit noise;
      noise = ($urandom_range(0, 99) < 15);
      if (op == OP_INSERT_AT && !noise)
         return 4'($urandom_range(0, (ledger.fill > 15) ? 15 : ledger.fill));
      if ((op == OP_REMOVE_AT || op == OP_READ_AT) && ledger.fill > 0 && !noise)
         return 4'($urandom_range(0, ledger.fill - 1));
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [2:0] pick_op(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         0: return (roll < 65) ? grow_ops[$urandom_range(0, 2)]
                  : (roll < 80) ? shrink_ops[$urandom_range(0, 2)]
                  : look_ops[$urandom_range(0, 1)];
         1: return (roll < 60) ? shrink_ops[$urandom_range(0, 2)]
                  : (roll < 80) ? grow_ops[$urandom_range(0, 2)]
                  : look_ops[$urandom_range(0, 1)];
         default: return every_op[$urandom_range(0, 7)];
      endcase
   endfunction

   task automatic send_random(input logic [2:0] op);
      send_request(op, pick_index(op), pick_value(op));
   endtask

   initial begin
      int sent;
      int mode;
      int k;
      logic [2:0] op;
      ledger           = new();
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.op        = OP_PUSH_FRONT;
      req_ch.index     = '0;
      req_ch.value     = '0;
      rsp_ch.ready     = 1'b0;
      gap_pct          = 30;
      stall_pct        = 30;
      stall_left       = 0;
      hold_off_request = 1'b0;
      cycle_count      = 0;
      sent             = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list, then a small list walked through every operation
      send_request(OP_POP_FRONT, 4'd0, 32'sd0);
      send_request(OP_POP_BACK, 4'd0, 32'sd0);
      send_request(OP_REMOVE_AT, 4'd0, 32'sd0);
      send_request(OP_READ_AT, 4'd0, 32'sd0);
      send_request(OP_FIND, 4'd0, 32'sd0);
      send_request(OP_INSERT_AT, 4'd1, 32'sd7);
      send_request(OP_INSERT_AT, 4'd0, 32'sh7FFF_FFFF);
      send_request(OP_PUSH_FRONT, 4'd15, 32'sh8000_0000);
      send_request(OP_PUSH_BACK, 4'd15, -32'sd1);
      send_request(OP_INSERT_AT, 4'd3, 32'sd0);
      send_request(OP_INSERT_AT, 4'd5, 32'sd9);
      send_request(OP_INSERT_AT, 4'd1, 32'sh5A5A_5A5A);
      send_request(OP_READ_AT, 4'd15, 32'sd0);
      send_request(OP_READ_AT, 4'd4, 32'sd0);
      send_request(OP_REMOVE_AT, 4'd5, 32'sd0);
      send_request(OP_FIND, 4'd0, 32'sh7FFF_FFFF);
      send_request(OP_FIND, 4'd0, 32'sd12345);
      send_request(OP_FIND, 4'd0, 32'sd0);
      send_request(OP_REMOVE_AT, 4'd1, 32'sd0);
      send_request(OP_POP_FRONT, 4'd0, 32'sd0);
      send_request(OP_POP_BACK, 4'd0, 32'sd0);
      send_request(OP_READ_AT, 4'd0, 32'sd0);

      // fill past capacity while the result side holds off, then shrink past empty
      hold_off_request = 1'b1;
      for (k = 0; k < 22; k++) send_random(grow_ops[k % 3]);
      for (k = 0; k < 22; k++) send_random(shrink_ops[k % 3]);

      while (sent < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         case ($urandom_range(0, 3))
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 10; stall_pct = 10; end
            2: begin gap_pct = 40; stall_pct = 20; end
            default: begin gap_pct = 20; stall_pct = 50; end
         endcase
         if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 50)
            hold_off_request = 1'b1;
         for (k = 0; k < 50; k++) begin
            op = pick_op(mode);
            send_random(op);
         end
         sent += 50;
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests over all operations (find %0d, insert at %0d, remove at %0d).",
               ledger.requests, ledger.op_seen[OP_FIND], ledger.op_seen[OP_INSERT_AT],
               ledger.op_seen[OP_REMOVE_AT]);
      $display("Outcomes: ok %0d, empty %0d, full %0d, not found %0d, bad index %0d.",
               ledger.status_seen[STAT_OK], ledger.status_seen[STAT_EMPTY],
               ledger.status_seen[STAT_FULL], ledger.status_seen[STAT_NOT_FOUND],
               ledger.status_seen[STAT_BAD_INDEX]);
      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("** ordered_list_deque_engine_unit: PASSED **");
      end else begin
         $display("%0t: %0d mismatches, %0d results never arrived",
                  $time, ledger.failures, ledger.pending());
         $display("** ordered_list_deque_engine_unit: FAILED **");
      end
      $finish;
   end

endmodule
